FILE: rtl/kfsi_pkg.sv
// Shared constants for the keyframe spline interpolator.
`default_nettype none

package kfsi_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_KEYS = 2'd1;
    localparam logic [1:0] CFG_DIM  = 2'd2;

    // input word function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // interpolation modes
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_SPLINE = 1'b1;

    typedef logic signed [3:0] t_coef;

    // Catmull-Rom basis (times 2), row = neighbor, column = power of h, high first
    localparam t_coef CR_COEF [16] = '{
        -4'sd1,  4'sd2, -4'sd1,  4'sd0,
         4'sd3, -4'sd5,  4'sd0,  4'sd2,
        -4'sd3,  4'sd4,  4'sd1,  4'sd0,
         4'sd1, -4'sd1,  4'sd0,  4'sd0
    };

endpackage

`default_nettype wire

FILE: rtl/keyframe_spline_interpolator_core.sv
// Keyframe table with linear / Catmull-Rom interpolation on one shared multiplier.
//
// A load word with a valid key index and slot writes one table entry and gives no
// result. A query runs a small sequencer around one memory port and one multiplier:
// a scan of the keys from key 0, a restoring divide for the segment fraction, a build
// of the four spline basis weights (spline mode only), then per component a read,
// multiply and accumulate for each neighbor key (two in linear mode, four in spline
// mode) and an output step. A query at or before the first key or past the last one
// skips the math and outputs the stored key values, one word per component. busy is high
// throughout; each result word is shown for exactly one cycle with o_strobe and
// cannot be stalled by the receiver.
`default_nettype none

module keyframe_spline_interpolator_core
    import kfsi_pkg::*;
#(
    parameter int MAX_KEYS = 64,
    parameter int MAX_DIM  = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_func,
    input  wire logic [5:0]         i_key_index,
    input  wire logic [2:0]         i_slot,
    input  wire logic signed [31:0] i_load_value,
    input  wire logic [30:0]        i_query_time,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [6:0]         i_cfg_data,
    output logic                    o_strobe,
    output logic [1:0]              o_component,
    output logic signed [31:0]      o_value,
    output logic                    o_last
);

    localparam int DEPTH = MAX_KEYS * (MAX_DIM + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_KEYS + 1);
    localparam int DW    = $clog2(MAX_DIM + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FIRST, S_SRCH, S_DIV, S_BM, S_BA, S_BR,
        S_EMRD, S_EMOUT, S_CRD, S_CMUL, S_CACC, S_COUT
    } t_state;

    t_state r_state;

    logic                r_mode;
    logic [6:0]          r_kc;
    logic [2:0]          r_dim;

    logic                r_qmode;
    logic [NW-1:0]       r_n;
    logic [DW-1:0]       r_d;
    logic [DW-1:0]       r_j;
    logic [NW-1:0]       r_k;
    logic [NW-1:0]       r_key;
    logic [32:0]         r_t;
    logic signed [32:0]  r_tprev;
    logic [33:0]         r_rem;
    logic [32:0]         r_den;
    logic [16:0]         r_h;
    logic [4:0]          r_cnt;
    logic [1:0]          r_i;
    logic [1:0]          r_s;
    logic signed [55:0]  r_p;
    logic signed [63:0]  r_prod;
    logic signed [63:0]  r_acc;
    logic signed [27:0]  r_b [4];
    logic signed [31:0]  r_rdata;

    logic signed [31:0]  mem [DEPTH];

    logic [AW-1:0]       w_addr;
    logic                w_we;
    logic signed [39:0]  w_ma;
    logic signed [32:0]  w_mb;
    logic signed [72:0]  w_prod;
    logic signed [32:0]  w_word;
    logic [33:0]         w_rem2;
    logic                w_qbit;
    logic [16:0]         w_hnew;
    logic [NW-1:0]       w_kn;
    logic signed [55:0]  w_cterm;
    logic signed [55:0]  w_bsum;
    logic signed [63:0]  w_rsum;
    logic signed [63:0]  w_res;
    logic signed [31:0]  w_sat;
    logic [NW-1:0]       w_nclamp;
    logic [DW-1:0]       w_dclamp;
    logic [1:0]          w_ifirst;

    function automatic logic [AW-1:0] f_addr(input logic [31:0] key, input logic [31:0] slot);
        logic [31:0] a;
        a = key * (MAX_DIM + 1) + slot;
        return a[AW-1:0];
    endfunction

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // clamped key count and dimension
    always_comb begin
        if (r_kc == 7'd0) begin
            w_nclamp = NW'(1);
        end else if (32'(r_kc) > MAX_KEYS) begin
            w_nclamp = NW'(MAX_KEYS);
        end else begin
            w_nclamp = NW'(r_kc);
        end
        if (r_dim == 3'd0) begin
            w_dclamp = DW'(1);
        end else if (32'(r_dim) > MAX_DIM) begin
            w_dclamp = DW'(MAX_DIM);
        end else begin
            w_dclamp = DW'(r_dim);
        end
    end

    // clamped neighbor key for spline tap r_i
    always_comb begin
        int kn;
        kn = int'(r_k) + int'(r_i) - 2;
        if (kn < 0) begin
            kn = 0;
        end else if (kn > int'(r_n) - 1) begin
            kn = int'(r_n) - 1;
        end
        w_kn = NW'(kn);
    end

    assign w_ifirst = (r_qmode == MODE_SPLINE) ? 2'd0 : 2'd1;
    assign w_word   = 33'(r_rdata);

    // divider step
    assign w_rem2 = (r_cnt == 5'd0) ? r_rem : {r_rem[32:0], 1'b0};
    assign w_qbit = (w_rem2 >= {1'b0, r_den});
    assign w_hnew = {r_h[15:0], w_qbit};

    // shared multiplier
    always_comb begin
        if (r_state == S_BM) begin
            w_ma = r_p[39:0];
            w_mb = {16'd0, r_h};
        end else begin
            w_ma = 40'(r_b[r_i]);
            w_mb = 33'(r_rdata);
        end
    end
    assign w_prod = w_ma * w_mb;

    always_comb begin
        case (r_s)
            2'd1:    w_cterm = 56'(CR_COEF[{r_i, r_s}]) <<< 16;
            2'd2:    w_cterm = 56'(CR_COEF[{r_i, r_s}]) <<< 32;
            2'd3:    w_cterm = 56'(CR_COEF[{r_i, r_s}]) <<< 48;
            default: w_cterm = 56'(CR_COEF[{r_i, r_s}]);
        endcase
    end
    assign w_bsum = r_p + (56'sd1 <<< 24);

    assign w_rsum = r_acc + (64'sd1 <<< 23);
    assign w_res  = w_rsum >>> 24;
    always_comb begin
        if (w_res > 64'sd2147483647) begin
            w_sat = 32'sh7fffffff;
        end else if (w_res < -64'sd2147483648) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_res[31:0];
        end
    end

    // memory address and write enable
    always_comb begin
        w_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_addr = '0;
                if (start && i_func == FUNC_LOAD) begin
                    w_addr = f_addr(32'(i_key_index), 32'(i_slot));
                    w_we   = (32'(i_key_index) < MAX_KEYS) && (32'(i_slot) <= MAX_DIM);
                end
            end
            S_FIRST: w_addr = f_addr(32'd1, 32'd0);
            S_SRCH:  w_addr = f_addr(32'(r_k) + 32'd1, 32'd0);
            S_EMRD:  w_addr = f_addr(32'(r_key), 32'(r_j) + 32'd1);
            S_CRD:   w_addr = f_addr(32'(w_kn), 32'(r_j) + 32'd1);
            default: w_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= i_load_value;
        end
        r_rdata <= mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINEAR;
            r_kc   <= 7'd1;
            r_dim  <= 3'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE: r_mode <= i_cfg_data[0];
                CFG_KEYS: r_kc   <= i_cfg_data;
                CFG_DIM:  r_dim  <= i_cfg_data[2:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
            o_last   <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            o_last   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start && i_func == FUNC_QUERY) begin
                        r_qmode <= r_mode;
                        r_n     <= w_nclamp;
                        r_d     <= w_dclamp;
                        r_t     <= {2'b00, i_query_time};
                        r_j     <= '0;
                        r_state <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    if (r_n == NW'(1) || $signed(r_t) <= w_word) begin
                        r_key   <= '0;
                        r_state <= S_EMRD;
                    end else begin
                        r_tprev <= w_word;
                        r_k     <= NW'(1);
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (w_word >= $signed(r_t)) begin
                        r_rem   <= {1'b0, 33'($signed(r_t) - r_tprev)};
                        r_den   <= 33'(w_word - r_tprev);
                        r_h     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (32'(r_k) + 32'd1 >= 32'(r_n)) begin
                        r_key   <= r_n - NW'(1);
                        r_state <= S_EMRD;
                    end else begin
                        r_tprev <= w_word;
                        r_k     <= r_k + NW'(1);
                    end
                end
                S_DIV: begin
                    r_rem <= w_qbit ? (w_rem2 - {1'b0, r_den}) : w_rem2;
                    r_h   <= w_hnew;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        if (r_qmode == MODE_SPLINE) begin
                            r_i     <= 2'd0;
                            r_s     <= 2'd1;
                            r_p     <= 56'(CR_COEF[0]);
                            r_state <= S_BM;
                        end else begin
                            r_b[0]  <= '0;
                            r_b[1]  <= {3'b000, 17'(17'd65536 - w_hnew), 8'h00};
                            r_b[2]  <= {3'b000, w_hnew, 8'h00};
                            r_b[3]  <= '0;
                            r_i     <= 2'd1;
                            r_acc   <= '0;
                            r_state <= S_CRD;
                        end
                    end
                end
                S_BM: begin
                    r_prod  <= w_prod[63:0];
                    r_state <= S_BA;
                end
                S_BA: begin
                    r_p <= r_prod[55:0] + w_cterm;
                    if (r_s == 2'd3) begin
                        r_state <= S_BR;
                    end else begin
                        r_s     <= r_s + 2'd1;
                        r_state <= S_BM;
                    end
                end
                S_BR: begin
                    r_b[r_i] <= w_bsum[52:25];
                    r_s      <= 2'd1;
                    if (r_i == 2'd3) begin
                        r_i     <= 2'd0;
                        r_acc   <= '0;
                        r_state <= S_CRD;
                    end else begin
                        r_p     <= 56'(CR_COEF[{r_i + 2'd1, 2'd0}]);
                        r_i     <= r_i + 2'd1;
                        r_state <= S_BM;
                    end
                end
                S_EMRD: r_state <= S_EMOUT;
                S_EMOUT: begin
                    o_strobe    <= 1'b1;
                    o_component <= 2'(r_j);
                    o_value     <= r_rdata;
                    o_last      <= (32'(r_j) + 32'd1 == 32'(r_d));
                    r_j         <= r_j + DW'(1);
                    r_state     <= (32'(r_j) + 32'd1 == 32'(r_d)) ? S_IDLE : S_EMRD;
                end
                S_CRD: r_state <= S_CMUL;
                S_CMUL: begin
                    r_prod  <= w_prod[63:0];
                    r_state <= S_CACC;
                end
                S_CACC: begin
                    r_acc <= r_acc + r_prod;
                    if (r_i == ((r_qmode == MODE_SPLINE) ? 2'd3 : 2'd2)) begin
                        r_state <= S_COUT;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_CRD;
                    end
                end
                S_COUT: begin
                    o_strobe    <= 1'b1;
                    o_component <= 2'(r_j);
                    o_value     <= w_sat;
                    o_last      <= (32'(r_j) + 32'd1 == 32'(r_d));
                    r_j         <= r_j + DW'(1);
                    r_acc       <= '0;
                    r_i         <= w_ifirst;
                    r_state     <= (32'(r_j) + 32'd1 == 32'(r_d)) ? S_IDLE : S_CRD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe) else $error("last without strobe");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_func == FUNC_QUERY |=> busy) else $error("query not taken");

    a_more_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy) else $error("query ended early");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_cnt != 5'd0 |-> r_rem < {1'b0, r_den})
        else $error("divider remainder out of range");

endmodule

`default_nettype wire
